FILE: sv/wwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windscreen wiper controller package
// Shared codes, constants and types for the wiper controller modules.
// ----------------------------------------------------------------------------
package wwc_pkg;

   localparam int unsigned POS_W       = 7;
   localparam int unsigned MS_W        = 16;
   localparam int unsigned THRESH_W    = 10;   // 65535 / 100 fits in 10 bits
   localparam int unsigned CSR_INDEX_W = 8;

   localparam logic [POS_W-1:0] POS_BOTTOM   = 7'd0;
   localparam logic [POS_W-1:0] POS_ONE      = 7'd1;
   localparam logic [POS_W-1:0] POS_NEAR_TOP = 7'd99;
   localparam logic [POS_W-1:0] POS_TOP      = 7'd100;

   // x / 100 for any 16-bit x equals (x * 167773) >> 24.
   localparam int unsigned         DIV100_SHIFT = 24;
   localparam int unsigned         DIV100_MUL_W = 18;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 18'd167773;

   localparam logic [MS_W-1:0]     SWEEP_RESET  = 16'd1000;
   localparam logic [MS_W-1:0]     PAUSE_RESET  = 16'd3000;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd10;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_UP    = 2'd1,
      FUNC_DOWN  = 2'd2,
      FUNC_PARK  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      SPEED_OFF        = 2'd0,
      SPEED_INTERMIT   = 2'd1,
      SPEED_CONTINUOUS = 2'd2
   } speed_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOLD_AT_TOP = 8'd0,
      CSR_SWEEP       = 8'd1,
      CSR_PAUSE       = 8'd2,
      CSR_SOUND_MODE  = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic                hold_at_top;
      logic                sound_mode;
      logic [MS_W-1:0]     pause_ms;
      logic [THRESH_W-1:0] step_thresh;
   } cfg_type;

   typedef struct packed {
      logic             switch_sound;
      logic             wipe_sound;
      logic             held;
      logic [1:0]       speed_level;
      logic             moving_up;
      logic [POS_W-1:0] position;
   } result_type;

endpackage

FILE: sv/wwc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wiper controller configuration registers
// Holds the four settings and keeps the per-step threshold (sweep / 100).
// ----------------------------------------------------------------------------
module wwc_csr
   import wwc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [MS_W-1:0]        csr_data,
   output cfg_type                cfg
);

   logic                                hold_ff, hold_in;
   logic                                sound_ff, sound_in;
   logic [MS_W-1:0]                     pause_ff, pause_in;
   logic [THRESH_W-1:0]                 thresh_ff, thresh_in;
   logic [MS_W+DIV100_MUL_W-1:0]        div_prod;

   // The sweep period itself is never read back, only its step threshold.
   assign div_prod = csr_data * DIV100_MUL;

   always_comb begin
      hold_in   = hold_ff;
      sound_in  = sound_ff;
      pause_in  = pause_ff;
      thresh_in = thresh_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HOLD_AT_TOP: hold_in   = csr_data[0];
            CSR_SWEEP:       thresh_in = div_prod[DIV100_SHIFT +: THRESH_W];
            CSR_PAUSE:       pause_in  = csr_data;
            CSR_SOUND_MODE:  sound_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         sound_ff  <= 1'b0;
         pause_ff  <= PAUSE_RESET;
         thresh_ff <= THRESH_RESET;
      end else begin
         hold_ff   <= hold_in;
         sound_ff  <= sound_in;
         pause_ff  <= pause_in;
         thresh_ff <= thresh_in;
      end
   end

   assign cfg.hold_at_top = hold_ff;
   assign cfg.sound_mode  = sound_ff;
   assign cfg.pause_ms    = pause_ff;
   assign cfg.step_thresh = thresh_ff;

endmodule

FILE: sv/wwc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wiper controller state update
// Holds the blade state and applies one item per enabled cycle.
// ----------------------------------------------------------------------------
module wwc_core
   import wwc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  func_type        func,
   input  logic [MS_W-1:0] delta_ms,
   input  cfg_type         cfg,
   output result_type      result
);

   // The step timer is only kept while it stays at or below a threshold, so it
   // never passes 655. The pause timer is only kept while it stays at or below
   // a 16-bit pause. Neither can reach saturation at these widths.
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                dir_ff, dir_in;
   speed_type           speed_ff, speed_in;
   logic [THRESH_W-1:0] step_ff, step_in;
   logic [MS_W-1:0]     pause_ff, pause_in;
   logic                held_ff, held_in;
   logic                click_ff, click_in;

   logic                at_low, at_high, at_park;
   logic                tick_dir, tick_held, do_step;
   logic [MS_W:0]       pause_sum, step_sum;
   logic                pause_over, step_over;
   logic [MS_W-1:0]     tick_pause;
   logic [THRESH_W-1:0] tick_step;
   logic [POS_W-1:0]    tick_pos;
   logic                tick_wipe;

   assign at_low  = (pos_ff == POS_BOTTOM);
   assign at_high = (pos_ff == POS_TOP);
   assign at_park = (at_low && !cfg.hold_at_top) || (at_high && cfg.hold_at_top);

   assign pause_sum  = {1'b0, pause_ff} + {1'b0, delta_ms};
   assign pause_over = pause_sum > {1'b0, cfg.pause_ms};
   assign step_sum   = {{(MS_W+1-THRESH_W){1'b0}}, step_ff} + {1'b0, delta_ms};
   assign step_over  = step_sum > {{(MS_W+1-THRESH_W){1'b0}}, cfg.step_thresh};

   always_comb begin
      tick_dir   = dir_ff;
      tick_held  = held_ff;
      tick_pause = pause_ff;
      if (at_low) begin
         tick_dir = 1'b1;
      end else if (at_high) begin
         tick_dir = 1'b0;
      end else begin
         tick_pause = '0;
      end
      if (at_park) begin
         unique case (speed_ff)
            SPEED_OFF: tick_held = 1'b1;
            SPEED_INTERMIT: begin
               tick_held  = !pause_over;
               tick_pause = pause_over ? '0 : pause_sum[MS_W-1:0];
            end
            default: tick_held = 1'b0;
         endcase
      end
      do_step = !at_park || !tick_held;

      tick_pos  = pos_ff;
      tick_step = step_ff;
      if (do_step) begin
         if (step_over) begin
            tick_step = '0;
            if (tick_dir) begin
               if (pos_ff < POS_TOP) tick_pos = pos_ff + POS_ONE;
            end else begin
               if (pos_ff > POS_BOTTOM) tick_pos = pos_ff - POS_ONE;
            end
         end else begin
            tick_step = step_sum[THRESH_W-1:0];
         end
      end

      tick_wipe = 1'b0;
      if (tick_pos == POS_ONE && tick_dir) begin
         tick_wipe = (cfg.hold_at_top == cfg.sound_mode);
      end else if (tick_pos == POS_NEAR_TOP && !tick_dir) begin
         tick_wipe = (cfg.hold_at_top != cfg.sound_mode);
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      dir_in   = dir_ff;
      speed_in = speed_ff;
      step_in  = step_ff;
      pause_in = pause_ff;
      held_in  = held_ff;
      click_in = click_ff;
      result.wipe_sound   = 1'b0;
      result.switch_sound = 1'b0;
      unique case (func)
         FUNC_UP: begin
            if (speed_ff == SPEED_OFF || speed_ff == SPEED_INTERMIT) begin
               speed_in = speed_type'(speed_ff + 2'd1);
               click_in = 1'b1;
            end
         end
         FUNC_DOWN: begin
            if (speed_ff != SPEED_OFF) begin
               speed_in = speed_type'(speed_ff - 2'd1);
               click_in = 1'b1;
            end
         end
         FUNC_PARK: pos_in = cfg.hold_at_top ? POS_TOP : POS_BOTTOM;
         FUNC_TICK: begin
            pos_in   = tick_pos;
            dir_in   = tick_dir;
            step_in  = tick_step;
            pause_in = tick_pause;
            held_in  = tick_held;
            click_in = 1'b0;
            result.wipe_sound   = tick_wipe;
            result.switch_sound = click_ff;
         end
         default: ;
      endcase
      result.position    = pos_in;
      result.moving_up   = dir_in;
      result.speed_level = speed_in;
      result.held        = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_BOTTOM;
         dir_ff   <= 1'b0;
         speed_ff <= SPEED_OFF;
         step_ff  <= '0;
         pause_ff <= '0;
         held_ff  <= 1'b0;
         click_ff <= 1'b0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         dir_ff   <= dir_in;
         speed_ff <= speed_in;
         step_ff  <= step_in;
         pause_ff <= pause_in;
         held_ff  <= held_in;
         click_ff <= click_in;
      end
   end

endmodule

FILE: sv/windscreen_wiper_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windscreen wiper controller
// Channel  | Direction | Contents
// req_     | in        | tuser = func, tdata = delta_ms
// rsp_     | out       | tdata = position, moving_up, speed_level, held,
//          |           |         wipe_sound, switch_sound
// csr_     | in        | csr_index, csr_data (write only, always ready)
//
// Each item goes from the input register through the state update into the
// output register; one item per cycle is sustained while rsp_tready is high.
// Reset is synchronous; it clears the valid flags and the blade state and
// loads the configuration defaults. A stalled result holds in the output
// register while the input register still takes one more transaction.
// ----------------------------------------------------------------------------
module windscreen_wiper_controller_unit
   import wwc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,   // [1:0] func
   input  logic [15:0]            req_tdata,   // [15:0] delta_ms
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,   // [6:0] position, [7] moving_up,
                                               // [9:8] speed_level, [10] held,
                                               // [11] wipe_sound, [12] switch_sound
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);

   logic            in_valid_ff, in_valid_in;
   func_type        in_func_ff;
   logic [MS_W-1:0] in_delta_ff;
   logic            out_valid_ff, out_valid_in;
   result_type      out_data_ff;
   result_type      result;
   cfg_type         cfg;
   logic            advance;

   assign csr_ready = 1'b1;

   wwc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   wwc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .func     (in_func_ff),
      .delta_ms (in_delta_ff),
      .cfg      (cfg),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_func_ff  <= func_type'(req_tuser);
         in_delta_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_data_ff};

endmodule
